// ----- sv/tcipi_pkg.sv -----
// Shared types and constants for the two-channel incremental PI controller.
// No dependencies; every other file refers to it by scoped names.
package tcipi_pkg;

  localparam int MAX_CH       = 2;
  localparam int CHANNELS_DEF = 2;
  localparam int DATA_W       = 32;
  localparam int PERIOD_W     = 16;
  localparam int IDX_W        = 3;
  localparam int IN_DATA_W    = 96;
  localparam int PROD_W       = 2 * DATA_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT_CH0  = 3'd0,
    REG_SETPOINT_CH1  = 3'd1,
    REG_RUN_MASK      = 3'd2,
    REG_GAIN_B_CH0    = 3'd3,
    REG_GAIN_C_CH0    = 3'd4,
    REG_GAIN_B_CH1    = 3'd5,
    REG_GAIN_C_CH1    = 3'd6,
    REG_SAMPLE_PERIOD = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [MAX_CH-1:0][DATA_W-1:0] setpoint;
    logic [MAX_CH-1:0][DATA_W-1:0] gain_b;
    logic [MAX_CH-1:0][DATA_W-1:0] gain_c;
    logic [MAX_CH-1:0]             run_mask;
    logic [PERIOD_W-1:0]           period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    setpoint: '0,
    gain_b:   '0,
    gain_c:   '0,
    run_mask: '0,
    period:   PERIOD_RESET
  };

endpackage

// ----- sv/tcipi_cfg.sv -----
// Configuration register file for the PI controller.
// Depends on tcipi_pkg for the register index codes and cfg_t.
module tcipi_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcipi_pkg::IDX_W-1:0] cfg_index,
  input  logic [tcipi_pkg::DATA_W-1:0] cfg_data,
  output tcipi_pkg::cfg_t            cfg
);

  tcipi_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tcipi_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      case (tcipi_pkg::reg_idx_t'(cfg_index))
        tcipi_pkg::REG_SETPOINT_CH0:  cfg_r.setpoint[0] <= cfg_data;
        tcipi_pkg::REG_SETPOINT_CH1:  cfg_r.setpoint[1] <= cfg_data;
        tcipi_pkg::REG_RUN_MASK:      cfg_r.run_mask    <= cfg_data[tcipi_pkg::MAX_CH-1:0];
        tcipi_pkg::REG_GAIN_B_CH0:    cfg_r.gain_b[0]   <= cfg_data;
        tcipi_pkg::REG_GAIN_C_CH0:    cfg_r.gain_c[0]   <= cfg_data;
        tcipi_pkg::REG_GAIN_B_CH1:    cfg_r.gain_b[1]   <= cfg_data;
        tcipi_pkg::REG_GAIN_C_CH1:    cfg_r.gain_c[1]   <= cfg_data;
        tcipi_pkg::REG_SAMPLE_PERIOD: cfg_r.period      <= cfg_data[tcipi_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/tcipi_mul.sv -----
// Input register, sample-time check, error and coefficient products.
// Holds the sample time and previous errors; depends on tcipi_pkg.
module tcipi_mul #(
  parameter int CHANNELS = tcipi_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcipi_pkg::cfg_t                   cfg,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tcipi_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                              take,
  output logic                              prod_vld,
  output logic [CHANNELS-1:0]               prod_mask,
  output logic [tcipi_pkg::PROD_W-1:0]      prod_p1 [CHANNELS],
  output logic [tcipi_pkg::PROD_W-1:0]      prod_p2 [CHANNELS]
);

  localparam int DW = tcipi_pkg::DATA_W;
  localparam int PW = tcipi_pkg::PROD_W;

  logic                      a_vld_r;
  logic [DW-1:0]             a_time_r;
  logic [CHANNELS-1:0][DW-1:0] a_fb_r;
  logic [DW-1:0]             last_time_r;
  logic [DW-1:0]             prev_err_r [CHANNELS];
  logic                      prod_vld_r;
  logic [CHANNELS-1:0]       prod_mask_r;
  logic [PW-1:0]             p1_r [CHANNELS];
  logic [PW-1:0]             p2_r [CHANNELS];

  logic                      b_free;
  logic                      a_adv;
  logic [DW-1:0]             elapsed;
  logic                      upd;
  logic [CHANNELS-1:0]       en;

  function automatic logic [DW-1:0] sat33(input logic signed [DW:0] v);
    if (v[DW] != v[DW-1]) begin
      return v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return v[DW-1:0];
  endfunction

  assign b_free    = !prod_vld_r || take;
  assign a_adv     = a_vld_r && b_free;
  assign in_tready = !a_vld_r || b_free;
  assign elapsed   = a_time_r - last_time_r;
  assign upd       = elapsed >= {{(DW-tcipi_pkg::PERIOD_W){1'b0}}, cfg.period};
  assign en        = cfg.run_mask[CHANNELS-1:0];

  assign prod_vld  = prod_vld_r;
  assign prod_mask = prod_mask_r;
  assign prod_p1   = p1_r;
  assign prod_p2   = p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      prod_vld_r  <= 1'b0;
      last_time_r <= '0;
    end else begin
      if (in_tready) begin
        a_vld_r <= in_tvalid;
      end
      if (b_free) begin
        prod_vld_r <= a_adv && upd && (|en);
      end
      if (a_adv && upd) begin
        last_time_r <= a_time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_time_r <= in_tdata[DW-1:0];
    end
    if (a_adv) begin
      prod_mask_r <= en;
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    logic signed [DW:0]  diff;
    logic [DW-1:0]       err;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;

    assign diff = $signed({cfg.setpoint[g][DW-1], cfg.setpoint[g]})
                - $signed({a_fb_r[g][DW-1], a_fb_r[g]});
    assign err  = sat33(diff);
    assign p1   = $signed(cfg.gain_b[g]) * $signed(err);
    assign p2   = $signed(cfg.gain_c[g]) * $signed(prev_err_r[g]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        prev_err_r[g] <= '0;
      end else if (a_adv && upd && en[g]) begin
        prev_err_r[g] <= err;
      end
    end

    always_ff @(posedge clk) begin
      if (in_tvalid && in_tready) begin
        a_fb_r[g] <= in_tdata[DW*(g+1) +: DW];
      end
      if (a_adv) begin
        p1_r[g] <= p1;
        p2_r[g] <= p2;
      end
    end
  end

endmodule

// ----- sv/tcipi_acc.sv -----
// Drive accumulation with saturation, and the result buffer that hands out
// one channel per item on the output stream. Depends on tcipi_pkg.
module tcipi_acc #(
  parameter int CHANNELS = tcipi_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          prod_vld,
  input  logic [CHANNELS-1:0]           prod_mask,
  input  logic [tcipi_pkg::PROD_W-1:0]  prod_p1 [CHANNELS],
  input  logic [tcipi_pkg::PROD_W-1:0]  prod_p2 [CHANNELS],
  output logic                          take,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tcipi_pkg::DATA_W-1:0]  out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  localparam int DW = tcipi_pkg::DATA_W;
  localparam int PW = tcipi_pkg::PROD_W;
  localparam int SW = PW + 2;

  logic [CHANNELS-1:0] pend_r;
  logic [DW-1:0]       prev_drive_r [CHANNELS];
  logic [CHANNELS-1:0] pend_rest;
  logic                single;

  function automatic logic [DW-1:0] sat66(input logic signed [SW-1:0] v);
    if ((v[SW-1:DW-1] == '0) || (v[SW-1:DW-1] == '1)) begin
      return v[DW-1:0];
    end
    return v[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  // pending channels other than the lowest one
  assign pend_rest  = pend_r & (pend_r - 1'b1);
  assign single     = (pend_r != '0) && (pend_rest == '0);
  assign take       = (pend_r == '0) || (out_tready && single);
  assign out_tvalid = |pend_r;
  assign out_tlast  = single;

  always_comb begin
    out_tuser = 1'b0;
    out_tdata = prev_drive_r[0];
    for (int k = CHANNELS - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        out_tuser = 1'(k);
        out_tdata = prev_drive_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (take) begin
      pend_r <= prod_vld ? prod_mask : '0;
    end else if (out_tready) begin
      // drop the channel just handed out
      pend_r <= pend_rest;
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    logic signed [SW-1:0] sum;

    assign sum = SW'($signed(prev_drive_r[g])) + SW'($signed(prod_p1[g]))
               + SW'($signed(prod_p2[g]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        prev_drive_r[g] <= '0;
      end else if (take && prod_vld && prod_mask[g]) begin
        prev_drive_r[g] <= sat66(sum);
      end
    end
  end

endmodule

// ----- sv/two_channel_incremental_pi.sv -----
// Two-channel incremental PI controller, top level.
// Registered in turn: input item, products, then the drive on the output.
// Throughput: one item per cycle when at most one channel runs and out_tready
// is high; with both running, the single result port hands out both results
// before the next products are taken. Reset (rst_n, synchronous, active low)
// clears control state, errors, drives and config; sample_period resets to one.
module two_channel_incremental_pi #(
  parameter int CHANNELS = tcipi_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcipi_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tcipi_pkg::DATA_W-1:0]  cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // sample_ms [31:0], feedback_ch0 [63:32], feedback_ch1 [95:64]
  input  logic [tcipi_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // drive [31:0]
  output logic [tcipi_pkg::DATA_W-1:0]  out_tdata,
  // channel [0]
  output logic                          out_tuser,
  output logic                          out_tlast
);

  tcipi_pkg::cfg_t                 cfg;
  logic                            take;
  logic                            prod_vld;
  logic [CHANNELS-1:0]             prod_mask;
  logic [tcipi_pkg::PROD_W-1:0]    prod_p1 [CHANNELS];
  logic [tcipi_pkg::PROD_W-1:0]    prod_p2 [CHANNELS];

  tcipi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tcipi_mul #(.CHANNELS(CHANNELS)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .prod_vld  (prod_vld),
    .prod_mask (prod_mask),
    .prod_p1   (prod_p1),
    .prod_p2   (prod_p2)
  );

  tcipi_acc #(.CHANNELS(CHANNELS)) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_vld   (prod_vld),
    .prod_mask  (prod_mask),
    .prod_p1    (prod_p1),
    .prod_p2    (prod_p2),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
